// ===== rtl/scale_degree_note_mapper_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Scale degree note mapper assertion macros
// Shared property forms for the mapper checks; they sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALE_DEGREE_NOTE_MAPPER_UNIT_MACROS_SVH
`define SCALE_DEGREE_NOTE_MAPPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDNM_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdnm check failed");

// The condition must never be seen.
`define SDNM_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sdnm forbidden condition seen");

`endif

// ===== rtl/sdnm_pkg.sv =====
// ----------------------------------------------------------------------------
// Scale degree note mapper package
// Shared constants, opcode and register codes, stage word types and the
// small lookup functions of the mapper pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdnm_pkg;

    // Scale geometry.
    localparam int MAX_SCALE_NOTES = 12;
    localparam int TABLE_ENTRIES   = 12;

    // Reset values of the configuration registers (major scale).
    localparam logic [3:0]  SCALE_SIZE_RESET = 4'd7;
    localparam logic [47:0] INTERVAL_RESET   = 48'h0000_0B97_5420;

    // Note range and the empty-scale default.
    localparam logic [6:0] EMPTY_NOTE = 7'd60;
    localparam logic [6:0] NOTE_MAX   = 7'd127;

    // Reciprocal division of the degree magnitude by the scale size.
    localparam int RECIP_SHIFT = 12;

    // Division by twelve of the biased note distance.
    localparam logic [9:0] DIV12_RECIP = 10'd683;
    localparam int         DIV12_SHIFT = 13;
    localparam logic [9:0] NOTE_BIAS   = 10'd240;
    localparam logic signed [6:0] NOTE_BIAS_OCT = 7'sd20;

    // Distance marking an entry that cannot be chosen.
    localparam logic [3:0] DIST_NONE = 4'd12;

    // Degree saturation limits.
    localparam logic signed [10:0] DEG_LOW  = -11'sd256;
    localparam logic signed [10:0] DEG_HIGH = 11'sd255;

    typedef enum logic {
        OP_DEG_TO_NOTE = 1'b0,
        OP_NOTE_TO_DEG = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_SCALE_SIZE     = 1'b0,
        REG_INTERVAL_TABLE = 1'b1
    } cfg_reg_t;

    // Word after decode.
    typedef struct packed {
        opcode_t           op;
        logic              neg;
        logic [6:0]        mag;
        logic [12:0]       recip;
        logic signed [9:0] base;
        logic [9:0]        xnote;
    } s1_t;

    // Word after the quotient multiplies.
    typedef struct packed {
        opcode_t           op;
        logic              neg;
        logic [6:0]        mag;
        logic [6:0]        q_deg;
        logic signed [9:0] base;
        logic [9:0]        xnote;
        logic [5:0]        q_note;
    } s2_t;

    // Word after octave and remainder resolution.
    typedef struct packed {
        opcode_t           op;
        logic signed [7:0] oct0;
        logic [3:0]        idx;
        logic signed [9:0] base;
        logic [3:0]        semi;
        logic signed [6:0] oct1;
    } s3_t;

    // Word after the table lookup and nearest-entry search.
    typedef struct packed {
        opcode_t            op;
        logic [6:0]         note;
        logic               flag;
        logic [3:0]         best;
        logic signed [10:0] oct_prod;
    } s4_t;

    // Effective scale size, limited to the table length.
    function automatic logic [3:0] eff_size(input logic [3:0] raw);
        return (raw > 4'(MAX_SCALE_NOTES)) ? 4'(MAX_SCALE_NOTES) : raw;
    endfunction

    // Ceiling of 4096 divided by the scale size; exact for magnitudes below 128.
    function automatic logic [12:0] recip_of(input logic [3:0] size);
        logic [12:0] r;
        case (size)
            4'd1:    r = 13'd4096;
            4'd2:    r = 13'd2048;
            4'd3:    r = 13'd1366;
            4'd4:    r = 13'd1024;
            4'd5:    r = 13'd820;
            4'd6:    r = 13'd683;
            4'd7:    r = 13'd586;
            4'd8:    r = 13'd512;
            4'd9:    r = 13'd456;
            4'd10:   r = 13'd410;
            4'd11:   r = 13'd373;
            4'd12:   r = 13'd342;
            default: r = 13'd0;
        endcase
        return r;
    endfunction

    // Semitone offset of one scale entry; entries past the table read as zero.
    function automatic logic [3:0] offset_at(input logic [47:0] tbl, input logic [3:0] idx);
        logic [3:0] v;
        if (idx < 4'(TABLE_ENTRIES)) begin
            v = tbl[{idx, 2'b00} +: 4];
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage

// ===== rtl/sdnm_divide.sv =====
// ----------------------------------------------------------------------------
// Scale degree note mapper front stages
// Decodes the input word and forms the two quotients: degree magnitude over
// scale size and biased note distance over twelve, both by reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdnm_divide
    import sdnm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        size_eff,
    input  logic              in_valid,
    output logic              in_ready,
    input  opcode_t           opcode,
    input  logic signed [7:0] degree_in,
    input  logic [6:0]        note_in,
    input  logic [3:0]        root_pitch,
    input  logic signed [4:0] base_octave,
    output logic              out_valid,
    input  logic              out_ready,
    output s2_t               out_word
);

    s1_t               s1_next;
    s1_t               s1_reg;
    logic              s1_valid_reg;
    logic              s1_ready;
    s2_t               s2_next;
    s2_t               s2_reg;
    logic              s2_valid_reg;
    logic signed [9:0] boct_ext;
    logic [19:0]       prod_deg;
    logic [19:0]       prod_note;

    // Decode: magnitude for floor division, root base and biased note distance.
    always_comb
    begin
        boct_ext      = {{5{base_octave[4]}}, base_octave};
        s1_next.op    = opcode;
        s1_next.neg   = degree_in[7];
        s1_next.mag   = degree_in[7] ? ~degree_in[6:0] : degree_in[6:0];
        s1_next.recip = recip_of(size_eff);
        s1_next.base  = (boct_ext <<< 3) + (boct_ext <<< 2) + $signed({6'd0, root_pitch});
        s1_next.xnote = {3'd0, note_in} - s1_next.base + NOTE_BIAS;
    end

    // Quotients by multiplication with the reciprocals.
    always_comb
    begin
        prod_deg       = {7'd0, s1_reg.recip} * {13'd0, s1_reg.mag};
        prod_note      = {10'd0, s1_reg.xnote} * {10'd0, DIV12_RECIP};
        s2_next.op     = s1_reg.op;
        s2_next.neg    = s1_reg.neg;
        s2_next.mag    = s1_reg.mag;
        s2_next.q_deg  = 7'(prod_deg >> RECIP_SHIFT);
        s2_next.base   = s1_reg.base;
        s2_next.xnote  = s1_reg.xnote;
        s2_next.q_note = 6'(prod_note >> DIV12_SHIFT);
    end

    // A stage takes a word when it is empty or its word moves on.
    assign in_ready  = !s1_valid_reg || s1_ready;
    assign s1_ready  = !s2_valid_reg || out_ready;
    assign out_valid = s2_valid_reg;
    assign out_word  = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg && s1_ready)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

// ===== rtl/sdnm_resolve.sv =====
// ----------------------------------------------------------------------------
// Scale degree note mapper resolve stage
// Turns the quotients into a floored octave with a positive scale index, and
// into a note octave with its semitone within the octave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdnm_resolve
    import sdnm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] size_eff,
    input  logic       in_valid,
    output logic       in_ready,
    input  s2_t        in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output s3_t        out_word
);

    s3_t         s3_next;
    s3_t         s3_reg;
    logic        s3_valid_reg;
    logic [10:0] qs;
    logic [3:0]  rem;
    logic [9:0]  q12;

    // Remainders and floored octaves; a negative degree mirrors the division.
    always_comb
    begin
        qs           = {4'd0, in_word.q_deg} * {7'd0, size_eff};
        rem          = 4'(in_word.mag - qs[6:0]);
        q12          = ({4'd0, in_word.q_note} << 3) + ({4'd0, in_word.q_note} << 2);
        s3_next.op   = in_word.op;
        s3_next.oct0 = in_word.neg ? $signed(~{1'b0, in_word.q_deg})
                                   : $signed({1'b0, in_word.q_deg});
        s3_next.idx  = in_word.neg ? (size_eff - 4'd1 - rem) : rem;
        s3_next.base = in_word.base;
        s3_next.semi = 4'(in_word.xnote - q12);
        s3_next.oct1 = $signed({1'b0, in_word.q_note}) - NOTE_BIAS_OCT;
    end

    assign in_ready  = !s3_valid_reg || out_ready;
    assign out_valid = s3_valid_reg;
    assign out_word  = s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s3_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

// ===== rtl/sdnm_select.sv =====
// ----------------------------------------------------------------------------
// Scale degree note mapper select stages
// Looks up the scale offset and clamps the note, searches the nearest scale
// entry with a compare tree, and forms the saturated degree and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdnm_select
    import sdnm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        size_eff,
    input  logic [47:0]       interval_table,
    input  logic              in_valid,
    output logic              in_ready,
    input  s3_t               in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [6:0]        note_out,
    output logic signed [8:0] degree_out,
    output logic              clamped
);

    typedef struct packed {
        logic [3:0] gap;
        logic [3:0] idx;
    } cand_t;

    s4_t                s4_next;
    s4_t                s4_reg;
    logic               s4_valid_reg;
    logic               s4_ready;
    logic               s5_valid_reg;
    logic [6:0]         note_next;
    logic [6:0]         note_reg;
    logic signed [8:0]  degree_next;
    logic signed [8:0]  degree_reg;
    logic               clamped_next;
    logic               clamped_reg;
    logic [3:0]         off;
    logic signed [11:0] oct_ext;
    logic signed [11:0] note_sum;
    logic signed [10:0] oct1_ext;
    logic signed [10:0] deg_sum;
    cand_t              lvl0 [TABLE_ENTRIES];
    cand_t              lvl1 [TABLE_ENTRIES / 2];
    cand_t              lvl2 [TABLE_ENTRIES / 4];
    cand_t              lvl3;
    cand_t              winner;

    // Keeps the left candidate unless the right one is strictly closer.
    function automatic cand_t pick(input cand_t a, input cand_t b);
        return (b.gap < a.gap) ? b : a;
    endfunction

    // Distance of every entry to the semitone; entries out of reach get the mark.
    always_comb
    begin
        logic [3:0] ofs;
        logic [3:0] diff;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            ofs  = offset_at(interval_table, 4'(i));
            diff = (ofs >= in_word.semi) ? (ofs - in_word.semi) : (in_word.semi - ofs);
            lvl0[i].idx = 4'(i);
            lvl0[i].gap = (4'(i) < size_eff && diff < DIST_NONE) ? diff : DIST_NONE;
        end
    end

    // Compare tree; ties keep the lower index.
    always_comb
    begin
        for (int j = 0; j < TABLE_ENTRIES / 2; j++)
        begin
            lvl1[j] = pick(lvl0[2 * j], lvl0[2 * j + 1]);
        end
        for (int k = 0; k < TABLE_ENTRIES / 4; k++)
        begin
            lvl2[k] = pick(lvl1[2 * k], lvl1[2 * k + 1]);
        end
        lvl3   = pick(lvl2[0], lvl2[1]);
        winner = pick(lvl3, lvl2[2]);
    end

    // Note path: offset lookup, octave and root, then clamp.
    always_comb
    begin
        off      = offset_at(interval_table, in_word.idx);
        oct_ext  = {{4{in_word.oct0[7]}}, in_word.oct0};
        note_sum = (oct_ext <<< 3) + (oct_ext <<< 2) + {{2{in_word.base[9]}}, in_word.base}
                   + $signed({8'd0, off});
        oct1_ext = {{4{in_word.oct1[6]}}, in_word.oct1};

        s4_next.op       = in_word.op;
        s4_next.best     = winner.idx;
        s4_next.oct_prod = oct1_ext * $signed({7'd0, size_eff});
        if (size_eff == 4'd0)
        begin
            s4_next.note = EMPTY_NOTE;
            s4_next.flag = 1'b1;
        end
        else if (note_sum < 12'sd0)
        begin
            s4_next.note = 7'd0;
            s4_next.flag = 1'b1;
        end
        else if (note_sum > $signed({5'd0, NOTE_MAX}))
        begin
            s4_next.note = NOTE_MAX;
            s4_next.flag = 1'b1;
        end
        else
        begin
            s4_next.note = note_sum[6:0];
            s4_next.flag = 1'b0;
        end
    end

    // Output word: one result kind per opcode, degree saturated.
    always_comb
    begin
        deg_sum = s4_reg.oct_prod + $signed({7'd0, s4_reg.best});
        if (s4_reg.op == OP_NOTE_TO_DEG)
        begin
            note_next = 7'd0;
            if (size_eff == 4'd0)
            begin
                degree_next  = 9'sd0;
                clamped_next = 1'b1;
            end
            else if (deg_sum < DEG_LOW)
            begin
                degree_next  = 9'(DEG_LOW);
                clamped_next = 1'b1;
            end
            else if (deg_sum > DEG_HIGH)
            begin
                degree_next  = 9'(DEG_HIGH);
                clamped_next = 1'b1;
            end
            else
            begin
                degree_next  = deg_sum[8:0];
                clamped_next = 1'b0;
            end
        end
        else
        begin
            note_next    = s4_reg.note;
            degree_next  = 9'sd0;
            clamped_next = s4_reg.flag;
        end
    end

    assign in_ready   = !s4_valid_reg || s4_ready;
    assign s4_ready   = !s5_valid_reg || out_ready;
    assign out_valid  = s5_valid_reg;
    assign note_out   = note_reg;
    assign degree_out = degree_reg;
    assign clamped    = clamped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s4_valid_reg <= in_valid;
            end
            if (s4_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s4_reg <= s4_next;
        end
        if (s4_valid_reg && s4_ready)
        begin
            note_reg    <= note_next;
            degree_reg  <= degree_next;
            clamped_reg <= clamped_next;
        end
    end

endmodule

// ===== rtl/scale_degree_note_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// Scale degree note mapper: five register stages, from decode to output. Throughput
// is one word per cycle while the output is not stalled; a stalled output holds
// every full stage in place. Reset empties the pipeline and loads a 7-note major
// scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scale_degree_note_mapper_unit_macros.svh"

module scale_degree_note_mapper_unit
    import sdnm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [47:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic signed [7:0] degree_in,
    input  logic [6:0]        note_in,
    input  logic [3:0]        root_pitch,
    input  logic signed [4:0] base_octave,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [6:0]        note_out,
    output logic signed [8:0] degree_out,
    output logic              clamped
);

    logic [3:0]  scale_size_reg;
    logic [47:0] interval_table_reg;
    logic [3:0]  size_eff;
    logic        div_valid;
    logic        div_ready;
    s2_t         div_word;
    logic        res_valid;
    logic        res_ready;
    s3_t         res_word;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_size_reg     <= SCALE_SIZE_RESET;
            interval_table_reg <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCALE_SIZE:     scale_size_reg     <= cfg_data[3:0];
                REG_INTERVAL_TABLE: interval_table_reg <= cfg_data;
                default:            scale_size_reg     <= scale_size_reg;
            endcase
        end
    end

    assign size_eff = eff_size(scale_size_reg);

    // Decode and quotient stages.
    sdnm_divide u_divide (
        .clk         (clk),
        .rst_n       (rst_n),
        .size_eff    (size_eff),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode_t'(opcode)),
        .degree_in   (degree_in),
        .note_in     (note_in),
        .root_pitch  (root_pitch),
        .base_octave (base_octave),
        .out_valid   (div_valid),
        .out_ready   (div_ready),
        .out_word    (div_word)
    );

    // Octave and remainder stage.
    sdnm_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_eff  (size_eff),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_word   (div_word),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_word  (res_word)
    );

    // Lookup, search and output stages.
    sdnm_select u_select (
        .clk            (clk),
        .rst_n          (rst_n),
        .size_eff       (size_eff),
        .interval_table (interval_table_reg),
        .in_valid       (res_valid),
        .in_ready       (res_ready),
        .in_word        (res_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .note_out       (note_out),
        .degree_out     (degree_out),
        .clamped        (clamped)
    );

    // A result carries either a note or a degree, never both.
    `SDNM_CHECK(a_single_kind, out_valid && note_out != 7'd0, degree_out == 9'sd0)
    // An empty scale always flags its result.
    `SDNM_CHECK(a_empty_flag, out_valid && size_eff == 4'd0, clamped)
    // Input back-pressure only comes from a full pipeline behind a stalled output.
    `SDNM_CHECK(a_stall_source, !in_ready, out_valid && !out_ready)
    // A flagged note is a range limit or the empty-scale default.
    `SDNM_NEVER(a_clamp_note, out_valid && clamped && note_out != 7'd0 && note_out != 7'd127 && note_out != 7'd60)

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Scale degree note mapper testbench
// Drives degree-to-note and note-to-degree words through the valid/ready
// ports under random sender gaps and receiver stalls. Each accepted word is
// mapped by a local model of the scale, and every result word is compared
// field by field. Several scale settings are loaded, with the block drained
// between them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import sdnm_pkg::*;
;

    localparam int STALL_LIMIT = 600;
    localparam int DRAIN_CYCLES = 10;

    // One input word as queued for the driver.
    typedef struct {
        opcode_t           op;
        logic signed [7:0] degree;
        logic [6:0]        note;
        logic [3:0]        root;
        logic signed [4:0] octave;
        logic              drain_first;
    } map_word_t;

    // One result word.
    typedef struct {
        logic [6:0]        note;
        logic signed [8:0] degree;
        logic              clamped;
    } map_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [0:0]        cfg_index = '0;
    logic [47:0]       cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              opcode = 1'b0;
    logic signed [7:0] degree_in = '0;
    logic [6:0]        note_in = '0;
    logic [3:0]        root_pitch = '0;
    logic signed [4:0] base_octave = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [6:0]        note_out;
    logic signed [8:0] degree_out;
    logic              clamped;

    // Local copy of the scale registers.
    logic [3:0]  scale_len = SCALE_SIZE_RESET;
    logic [47:0] scale_steps = INTERVAL_RESET;

    map_word_t   pending_words_q[$];
    map_result_t mapping_expect_q[$];
    map_word_t   drive_word;
    int          words_queued = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          idle_style = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    int          stall_cycles = 0;

    scale_degree_note_mapper_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .degree_in   (degree_in),
        .note_in     (note_in),
        .root_pitch  (root_pitch),
        .base_octave (base_octave),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .note_out    (note_out),
        .degree_out  (degree_out),
        .clamped     (clamped)
    );

    always #6 clk = ~clk;

    // Quotient rounded toward minus infinity.
    function automatic int floor_div(input int a, input int n);
        int q;
        q = a / n;
        if ((a % n) != 0 && a < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Semitone step of one scale entry; entries past the twelfth read as zero.
    function automatic int step_of(input int i);
        if (i >= 12) begin
            return 0;
        end
        return int'(scale_steps[4 * i +: 4]);
    endfunction

    // Expected result of one word under the current scale.
    function automatic map_result_t predict_mapping(input map_word_t w);
        map_result_t r;
        int size;
        int base;
        int oct;
        int idx;
        int n;
        int rel;
        int semi;
        int best;
        int best_dist;
        int d;
        int i;
        r.note = '0;
        r.degree = '0;
        r.clamped = 1'b0;
        size = (int'(scale_len) > MAX_SCALE_NOTES) ? MAX_SCALE_NOTES : int'(scale_len);
        base = int'(w.octave) * 12 + int'(w.root);
        if (size == 0) begin
            // An empty scale gives the default note and a zero degree.
            r.clamped = 1'b1;
            if (w.op == OP_DEG_TO_NOTE) begin
                r.note = EMPTY_NOTE;
            end
        end else if (w.op == OP_DEG_TO_NOTE) begin
            oct = floor_div(int'(w.degree), size);
            idx = int'(w.degree) - oct * size;
            n = base + step_of(idx) + 12 * oct;
            if (n < 0) begin
                n = 0;
                r.clamped = 1'b1;
            end else if (n > 127) begin
                n = 127;
                r.clamped = 1'b1;
            end
            r.note = n[6:0];
        end else begin
            rel = int'(w.note) - base;
            oct = floor_div(rel, 12);
            semi = rel - oct * 12;
            best = 0;
            best_dist = 12;
            // Nearest entry within the octave; the first one wins a tie.
            for (i = 0; i < size; i++) begin
                d = step_of(i) - semi;
                if (d < 0) begin
                    d = -d;
                end
                if (d < best_dist) begin
                    best_dist = d;
                    best = i;
                end
            end
            d = oct * size + best;
            if (d < -256) begin
                d = -256;
                r.clamped = 1'b1;
            end else if (d > 255) begin
                d = 255;
                r.clamped = 1'b1;
            end
            r.degree = d[8:0];
        end
        return r;
    endfunction

    // Cycles to wait after one word, by the idling style of the phase.
    function automatic int draw_gap();
        int g;
        case (idle_style)
            0: g = 0;
            1: g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            default: g = $urandom_range(0, 17);
        endcase
        return g;
    endfunction

    function automatic map_word_t random_word();
        map_word_t w;
        w.op = opcode_t'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) begin
            w.degree = 8'($urandom);
        end else begin
            w.degree = 8'($urandom_range(0, 40) - 20);
        end
        w.note = 7'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            w.root = 4'($urandom);
        end else begin
            w.root = 4'($urandom_range(0, 11));
        end
        if ($urandom_range(0, 2) == 0) begin
            w.octave = 5'($urandom);
        end else begin
            w.octave = 5'($urandom_range(0, 12) - 2);
        end
        w.drain_first = ($urandom_range(0, 49) == 0);
        return w;
    endfunction

    task automatic queue_word(input map_word_t w);
        pending_words_q.push_back(w);
        words_queued++;
    endtask

    task automatic queue_fields(input opcode_t op, input int degree, input int note,
                                input int root, input int octave);
        map_word_t w;
        w.op = op;
        w.degree = 8'(degree);
        w.note = 7'(note);
        w.root = 4'(root);
        w.octave = 5'(octave);
        w.drain_first = 1'b0;
        queue_word(w);
    endtask

    // Register write; only issued while the block is drained.
    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SCALE_SIZE) begin
            scale_len = value[3:0];
        end else begin
            scale_steps = value;
        end
    endtask

    // Wait until every queued word has produced its result, then let the pipe settle.
    task automatic wait_drained();
        while (results_seen < words_queued) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Input driver: presents queued words and predicts each accepted one.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_valid && in_ready) begin
                mapping_expect_q.push_back(predict_mapping(drive_word));
            end
            if (!in_valid || in_ready) begin
                if (send_wait > 0) begin
                    in_valid <= 1'b0;
                    send_wait--;
                end else if (pending_words_q.size() != 0 &&
                             !(pending_words_q[0].drain_first &&
                               mapping_expect_q.size() != 0)) begin
                    drive_word = pending_words_q.pop_front();
                    opcode <= drive_word.op;
                    degree_in <= drive_word.degree;
                    note_in <= drive_word.note;
                    root_pitch <= drive_word.root;
                    base_octave <= drive_word.octave;
                    in_valid <= 1'b1;
                    send_wait = draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: stalls at random and checks each result word.
    always @(posedge clk or negedge rst_n) begin
        map_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (mapping_expect_q.size() == 0) begin
                    $error("unexpected result word: note_out %0d degree_out %0d clamped %0b",
                           note_out, degree_out, clamped);
                    fail_count++;
                end else begin
                    want = mapping_expect_q.pop_front();
                    if (note_out !== want.note) begin
                        $error("note_out: expected %0d, actual %0d", want.note, note_out);
                        fail_count++;
                    end
                    if (degree_out !== want.degree) begin
                        $error("degree_out: expected %0d, actual %0d", want.degree, degree_out);
                        fail_count++;
                    end
                    if (clamped !== want.clamped) begin
                        $error("clamped: expected %0b, actual %0b", want.clamped, clamped);
                        fail_count++;
                    end
                end
                recv_wait = draw_gap();
            end
            if (recv_wait > 0) begin
                out_ready <= 1'b0;
                recv_wait--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Stimulus: directed words on a few scales, then random phases.
    initial begin
        int phase_sizes[11];
        logic [47:0] table_word;
        int step;
        int ph;
        int k;
        map_word_t w;

        phase_sizes = '{12, 1, 15, 0, 7, 13, 5, 12, 3, 14, 9};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Major scale after reset: range edges, floor octave, ties, odd roots.
        idle_style = 1;
        queue_fields(OP_DEG_TO_NOTE, 0, 0, 0, 5);
        queue_fields(OP_DEG_TO_NOTE, 127, 0, 0, 10);
        queue_fields(OP_DEG_TO_NOTE, -128, 0, 0, -2);
        queue_fields(OP_DEG_TO_NOTE, -1, 0, 11, 4);
        queue_fields(OP_DEG_TO_NOTE, -7, 0, 0, 5);
        queue_fields(OP_DEG_TO_NOTE, -8, 0, 0, 5);
        queue_fields(OP_DEG_TO_NOTE, 7, 0, 15, 15);
        queue_fields(OP_DEG_TO_NOTE, 3, 0, 4, -16);
        queue_fields(OP_NOTE_TO_DEG, 0, 0, 0, 0);
        queue_fields(OP_NOTE_TO_DEG, 0, 127, 0, 0);
        queue_fields(OP_NOTE_TO_DEG, 0, 61, 0, 5);
        queue_fields(OP_NOTE_TO_DEG, 0, 59, 0, 5);
        queue_fields(OP_NOTE_TO_DEG, 0, 0, 15, 15);
        wait_drained();

        // Empty scale.
        write_reg(REG_SCALE_SIZE, 48'd0);
        queue_fields(OP_DEG_TO_NOTE, 5, 0, 0, 5);
        queue_fields(OP_DEG_TO_NOTE, -128, 0, 11, -2);
        queue_fields(OP_NOTE_TO_DEG, 0, 64, 0, 5);
        wait_drained();

        // Twelve entries with steps above eleven; degree saturation.
        write_reg(REG_SCALE_SIZE, 48'd12);
        write_reg(REG_INTERVAL_TABLE, 48'hFED_CBA9_8765_4);
        queue_fields(OP_NOTE_TO_DEG, 0, 127, 0, -16);
        queue_fields(OP_NOTE_TO_DEG, 0, 0, 15, 15);
        queue_fields(OP_NOTE_TO_DEG, 0, 60, 0, 5);
        queue_fields(OP_DEG_TO_NOTE, 11, 0, 0, 5);
        wait_drained();

        // A single far step no note can reach, then an oversized count.
        write_reg(REG_SCALE_SIZE, 48'd1);
        write_reg(REG_INTERVAL_TABLE, 48'hF);
        queue_fields(OP_NOTE_TO_DEG, 0, 60, 0, 5);
        queue_fields(OP_DEG_TO_NOTE, 0, 0, 0, 5);
        wait_drained();
        write_reg(REG_SCALE_SIZE, 48'd15);
        queue_fields(OP_DEG_TO_NOTE, 13, 0, 0, 4);
        queue_fields(OP_NOTE_TO_DEG, 0, 70, 0, 4);
        wait_drained();

        // Random phases, each on its own scale setting.
        for (ph = 0; ph < 11; ph++) begin
            case (ph % 4)
                0: table_word = 48'({$urandom, $urandom});
                1: begin
                    // Ascending steps as in an ordinary scale.
                    step = 0;
                    for (k = 0; k < 12; k++) begin
                        table_word[4 * k +: 4] = 4'(step);
                        step = step + $urandom_range(1, 2);
                        if (step > 11) begin
                            step = 11;
                        end
                    end
                end
                2: table_word = 48'hFFFF_FFFF_FFFF;
                default: table_word = 48'h0;
            endcase
            write_reg(REG_SCALE_SIZE, 48'(phase_sizes[ph]));
            write_reg(REG_INTERVAL_TABLE, table_word);
            idle_style = ph % 3;
            for (k = 0; k < 66; k++) begin
                w = random_word();
                if (k == 30) begin
                    w.drain_first = 1'b1;
                end
                queue_word(w);
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
